>>> rtl/crds_pkg.sv
// ----------------------------------------------------------------------------
// crds_pkg
// Shared types and constants for the clock region delay step block: beat
// payloads, the internal region record and the operation codes.
// ----------------------------------------------------------------------------
package crds_pkg;

  // list and byte geometry of the packed region words
  localparam int BYTE_W         = 8;
  localparam int LIST_MAX       = 8;
  localparam int NUM_CLOCKS_DEF = 8;
  localparam int VALUE_BITS_DEF = 8;

  // operation codes
  localparam logic OP_SUCC = 1'b0;
  localparam logic OP_PRED = 1'b1;

  // input beat
  typedef struct packed {
    logic        opcode;
    logic [63:0] clock_values;
    logic [7:0]  zero_frac_mask;
    logic [63:0] bounded_sets;
    logic [3:0]  bounded_count;
    logic [63:0] unbounded_sets;
    logic [3:0]  unbounded_count;
  } in_t;

  // output beat
  typedef struct packed {
    logic        found;
    logic [63:0] clock_values_out;
    logic [7:0]  zero_frac_mask_out;
    logic [63:0] bounded_sets_out;
    logic [3:0]  bounded_count_out;
    logic [63:0] unbounded_sets_out;
    logic [3:0]  unbounded_count_out;
    logic        last;
  } out_t;

  // normalized region, unused entries and clocks held at zero
  typedef struct packed {
    logic [63:0] hv;
    logic [7:0]  x0;
    logic [63:0] b;
    logic [3:0]  nb;
    logic [63:0] u;
    logic [3:0]  nu;
  } region_t;

endpackage

>>> rtl/clock_region_delay_step_top.sv
// ----------------------------------------------------------------------------
// clock_region_delay_step_top
// Immediate delay successor or delay predecessors of a timed automaton clock
// region, three register stages: normalize, per-clock compare, assemble.
// An input beat passes the stage 1, stage 2 and stage 3 registers to the first output beat.
// Throughput: one input per cycle while each input gives one result and
// out_stall is low; a predecessor burst of three results stalls the input
// until its last beat leaves the output register.
// The output beat register in the assemble stage holds up to three results.
// Reset (rst, synchronous): clears valid bits, burst index and max_constant.
// ----------------------------------------------------------------------------
module clock_region_delay_step_top #(
  parameter int NUM_CLOCKS = crds_pkg::NUM_CLOCKS_DEF,
  parameter int VALUE_BITS = crds_pkg::VALUE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  crds_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output crds_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata
);
  import crds_pkg::*;

  localparam logic [7:0] CLK_MASK = 8'((1 << NUM_CLOCKS) - 1);
  localparam logic [7:0] VAL_MASK = 8'((1 << VALUE_BITS) - 1);

  logic [7:0] max_constant;
  logic       adv;

  // stage 1 registers
  logic       s1_valid;
  logic       s1_op;
  region_t    s1_r;
  region_t    norm_r;

  // stage 2 registers
  logic        s2_valid;
  logic        s2_op;
  region_t     s2_r;
  logic [7:0]  s2_eqmc;
  logic [7:0]  s2_zmask;
  logic [63:0] s2_hinc;
  logic [63:0] s2_hdec;
  logic [7:0]  s2_lastset;
  logic [63:0] s2_bpop;
  logic [3:0]  s2_nbm1;
  logic [7:0]  eqmc_next;
  logic [7:0]  zmask_next;
  logic [63:0] hinc_next;
  logic [63:0] hdec_next;
  logic [7:0]  lastset_next;
  logic [63:0] bpop_next;
  logic [3:0]  nbm1_next;

  // stage 3 registers, also the output beat register
  logic           s3_valid;
  logic           s3_op;
  out_t [2:0]     s3_res;
  logic [1:0]     s3_cnt;
  logic [1:0]     s3_idx;
  out_t [2:0]     res_next;
  logic [1:0]     cnt_next;

  function automatic out_t to_out(region_t r);
    out_t o;
    o.found               = 1'b1;
    o.clock_values_out    = r.hv;
    o.zero_frac_mask_out  = r.x0;
    o.bounded_sets_out    = r.b;
    o.bounded_count_out   = r.nb;
    o.unbounded_sets_out  = r.u;
    o.unbounded_count_out = r.nu;
    o.last                = 1'b0;
    return o;
  endfunction

  // whole pipeline moves when the output register is free or drains its last beat
  assign adv      = !s3_valid || (!out_stall && (s3_idx == s3_cnt));
  assign in_stall = !adv;

  // stage 1: mask clocks and sets, clamp counts, zero unused list entries
  always_comb begin
    norm_r    = '0;
    norm_r.nb = (in_data.bounded_count > 4'd8) ? 4'd8 : in_data.bounded_count;
    norm_r.nu = (in_data.unbounded_count > 4'd8) ? 4'd8 : in_data.unbounded_count;
    norm_r.x0 = in_data.zero_frac_mask & CLK_MASK;
    for (int k = 0; k < LIST_MAX; k++) begin
      if (k < NUM_CLOCKS) begin
        norm_r.hv[BYTE_W*k +: BYTE_W] = in_data.clock_values[BYTE_W*k +: BYTE_W] & VAL_MASK;
      end
      if (4'(k) < norm_r.nb) begin
        norm_r.b[BYTE_W*k +: BYTE_W] = in_data.bounded_sets[BYTE_W*k +: BYTE_W] & CLK_MASK;
      end
      if (4'(k) < norm_r.nu) begin
        norm_r.u[BYTE_W*k +: BYTE_W] = in_data.unbounded_sets[BYTE_W*k +: BYTE_W] & CLK_MASK;
      end
    end
  end

  // stage 2: per-clock compares, inc and dec, back entry of the bounded list
  always_comb begin
    logic [5:0] shamt;
    nbm1_next = s1_r.nb - 4'd1;
    shamt     = {nbm1_next[2:0], 3'b000};
    for (int i = 0; i < LIST_MAX; i++) begin
      eqmc_next[i]  = s1_r.x0[i] && (s1_r.hv[BYTE_W*i +: BYTE_W] == max_constant);
      zmask_next[i] = s1_r.x0[i] && (s1_r.hv[BYTE_W*i +: BYTE_W] == 8'd0);
      hinc_next[BYTE_W*i +: BYTE_W] = (s1_r.hv[BYTE_W*i +: BYTE_W] == VAL_MASK) ?
          s1_r.hv[BYTE_W*i +: BYTE_W] : s1_r.hv[BYTE_W*i +: BYTE_W] + 8'd1;
      hdec_next[BYTE_W*i +: BYTE_W] = s1_r.hv[BYTE_W*i +: BYTE_W] - 8'd1;
    end
    lastset_next = 8'(s1_r.b >> shamt);
    bpop_next    = s1_r.b & ~(64'hFF << shamt);
  end

  // stage 3: build the result regions of the burst
  always_comb begin
    region_t    rs;
    region_t    r1;
    region_t    r2;
    logic [7:0] tmp;
    logic [7:0] oob;
    logic [5:0] shnb;
    rs       = s2_r;
    r1       = s2_r;
    r2       = s2_r;
    tmp      = s2_r.x0 & ~s2_eqmc;
    oob      = s2_eqmc;
    shnb     = {s2_r.nb[2:0], 3'b000};
    res_next = '0;
    cnt_next = 2'd0;
    if (s2_op == OP_SUCC) begin
      if (s2_r.x0 != 8'd0) begin
        // zero-fraction clocks start a new front set
        rs.x0 = 8'd0;
        if (tmp != 8'd0 && s2_r.nb < 4'd8) begin
          rs.b  = {s2_r.b[55:0], tmp};
          rs.nb = s2_r.nb + 4'd1;
        end
        if (oob != 8'd0 && s2_r.nu < 4'd8) begin
          rs.u  = {s2_r.u[55:0], oob};
          rs.nu = s2_r.nu + 4'd1;
        end
      end else if (s2_r.nb != 4'd0) begin
        // last bounded set reaches the next integer
        rs.b  = s2_bpop;
        rs.nb = s2_nbm1;
        rs.x0 = s2_lastset;
        for (int i = 0; i < LIST_MAX; i++) begin
          if (s2_lastset[i]) begin
            rs.hv[BYTE_W*i +: BYTE_W] = s2_hinc[BYTE_W*i +: BYTE_W];
          end
        end
      end
      res_next[0] = to_out(rs);
    end else begin
      if (s2_r.nb == 4'd0 && s2_r.x0 == 8'd0) begin
        // front unbounded set moves to zero fraction
        rs.x0 = s2_r.u[7:0];
        if (s2_r.nu != 4'd0) begin
          rs.u  = s2_r.u >> BYTE_W;
          rs.nu = s2_r.nu - 4'd1;
        end
        res_next[0] = to_out(rs);
      end else if (s2_r.x0 != 8'd0) begin
        if (s2_zmask != 8'd0) begin
          // a clock would go negative: no predecessor
          res_next[0] = '0;
        end else begin
          for (int i = 0; i < LIST_MAX; i++) begin
            if (s2_r.x0[i]) begin
              rs.hv[BYTE_W*i +: BYTE_W] = s2_hdec[BYTE_W*i +: BYTE_W];
            end
          end
          if (s2_r.nb < 4'd8) begin
            rs.b  = s2_r.b | (64'(s2_r.x0) << shnb);
            rs.nb = s2_r.nb + 4'd1;
          end
          rs.x0       = 8'd0;
          res_next[0] = to_out(rs);
        end
      end else begin
        // front bounded set moves to zero fraction, unbounded variants first
        rs.x0 = s2_r.b[7:0];
        rs.b  = s2_r.b >> BYTE_W;
        rs.nb = s2_r.nb - 4'd1;
        if (s2_r.nu != 4'd0) begin
          r1.x0 = s2_r.u[7:0];
          r1.u  = s2_r.u >> BYTE_W;
          r1.nu = s2_r.nu - 4'd1;
          r2    = r1;
          r2.x0 = r1.x0 | s2_r.b[7:0];
          r2.b  = s2_r.b >> BYTE_W;
          r2.nb = s2_r.nb - 4'd1;
          res_next[0] = to_out(r1);
          res_next[1] = to_out(r2);
          res_next[2] = to_out(rs);
          cnt_next    = 2'd2;
        end else begin
          res_next[0] = to_out(rs);
        end
      end
    end
  end

  // control: valid bits, burst index, config register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s3_idx       <= 2'd0;
      max_constant <= 8'd0;
    end else begin
      if (cfg_we) begin
        max_constant <= cfg_wdata;
      end
      if (adv) begin
        s1_valid <= in_valid;
        s2_valid <= s1_valid;
        s3_valid <= s2_valid;
        s3_idx   <= 2'd0;
      end else if (!out_stall) begin
        s3_idx <= s3_idx + 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op      <= in_data.opcode;
      s1_r       <= norm_r;
      s2_op      <= s1_op;
      s2_r       <= s1_r;
      s2_eqmc    <= eqmc_next;
      s2_zmask   <= zmask_next;
      s2_hinc    <= hinc_next;
      s2_hdec    <= hdec_next;
      s2_lastset <= lastset_next;
      s2_bpop    <= bpop_next;
      s2_nbm1    <= nbm1_next;
      s3_op      <= s2_op;
      s3_res     <= res_next;
      s3_cnt     <= cnt_next;
    end
  end

  // output beat
  always_comb begin
    out_data      = s3_res[s3_idx];
    out_data.last = (s3_idx == s3_cnt);
  end
  assign out_valid = s3_valid;

  // burst index stays inside the burst
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (s3_idx <= s3_cnt))
    else $error("burst index beyond last result");

  // a non-final beat keeps the input stalled
  a_burst_hold: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && (s3_idx != s3_cnt)) |-> in_stall)
    else $error("input taken during a burst");

  // a missing predecessor is a single final beat
  a_notfound_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.found) |-> (out_data.last && (s3_cnt == 2'd0)))
    else $error("not-found result is not a lone final beat");

  // successors give exactly one result
  a_succ_single: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && (s3_op == OP_SUCC)) |-> (s3_cnt == 2'd0))
    else $error("successor burst longer than one");

endmodule
